/* rtl/core/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
`default_nettype none

package u8u16_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int CAP_WIDTH       = 12;
    localparam int CMP_WIDTH       = 17;
    localparam int CP_WIDTH        = 21;
    localparam int UNIT_WIDTH      = 16;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_CAPACITY  = 2'd2;

    localparam logic KIND_UNIT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [15:0] HI_SURR_BASE = 16'hd800;
    localparam logic [15:0] LO_SURR_BASE = 16'hdc00;
    localparam logic [20:0] SURR_FIRST   = 21'h00d800;
    localparam logic [20:0] SURR_LAST    = 21'h00dfff;
    localparam logic [20:0] BMP_LIMIT    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10ffff;
    localparam logic [20:0] TWO_BYTE_MIN = 21'h000080;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;

    typedef struct packed {
        logic                  kind;
        logic [UNIT_WIDTH-1:0] code_unit;
        logic [1:0]            status;
        logic [CAP_WIDTH-1:0]  unit_total;
        logic                  last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/utf8_to_utf16_transcoder_core.sv */
// UTF-8 to UTF-16 transcoder: top level, byte decode and 4-deep result queue.
// Depends on u8u16_pkg.
// Results are registered into the result queue when their byte is accepted and offered from its head.
// Throughput: one byte per cycle while s_tready (two or fewer queued results) is high;
// a surrogate pair takes two output beats, and the queue drains one per cycle while m_tready is high.
// Reset (rst_n, async, low): decode state and queue cleared, capacity 4095.
`default_nettype none

module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CAP_WIDTH-1:0] cfg_wdata,   // unit_capacity
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,     // text_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,     // code_unit, status, unit_total, pad
    output logic                      m_tuser,     // kind
    output logic                      m_tlast      // last_of_run
);

    localparam logic [CMP_WIDTH-1:0] CNT_MAX = CMP_WIDTH'((1 << COUNT_WIDTH) - 1);

    logic [CAP_WIDTH-1:0]   cap_reg;
    logic [CP_WIDTH-1:0]    pcp_reg, pcp_next;
    logic [1:0]             exp_reg, exp_next;
    logic [1:0]             seq_reg, seq_next;
    logic [COUNT_WIDTH-1:0] units_reg, units_next;
    logic [1:0]             err_reg, err_next;

    result_t                res0, res1;
    logic [1:0]             push_n;

    result_t                fifo_reg [4];
    logic [1:0]             wptr_reg, rptr_reg;
    logic [2:0]             cnt_reg;

    logic                   s_acc, m_acc;
    logic [7:0]             b;
    logic [CMP_WIDTH-1:0]   cap_eff, units_ext;
    logic                   do_emit;
    logic [CP_WIDTH-1:0]    cp, cp_full, cp_off;
    logic                   cp_bad;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= 3'd2);
    assign b        = s_tdata;

    always_comb
    begin
        cap_eff   = CMP_WIDTH'(cap_reg);
        if (cap_eff > CNT_MAX)
        begin
            cap_eff = CNT_MAX;
        end
        units_ext = CMP_WIDTH'(units_reg);
    end

    always_comb
    begin
        pcp_next   = pcp_reg;
        exp_next   = exp_reg;
        seq_next   = seq_reg;
        units_next = units_reg;
        err_next   = err_reg;
        do_emit    = 1'b0;
        cp         = CP_WIDTH'(b);
        cp_full    = {pcp_reg[CP_WIDTH-7:0], b[5:0]};
        cp_bad     = 1'b0;
        cp_off     = '0;
        push_n     = 2'd0;
        res0       = '0;
        res1       = '0;

        if (b == 8'h00)
        begin
            res0.kind       = KIND_END;
            res0.status     = (err_reg == ERR_NONE && exp_reg != 2'd0) ? ERR_MALFORMED
                                                                        : err_reg;
            res0.unit_total = CAP_WIDTH'(units_ext);
            res0.last       = 1'b1;
            push_n          = 2'd1;
            pcp_next        = '0;
            exp_next        = 2'd0;
            seq_next        = 2'd0;
            units_next      = '0;
            err_next        = ERR_NONE;
        end
        else if (err_reg != ERR_NONE)
        begin
            // dropped until terminator
        end
        else if (exp_reg == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                do_emit = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                pcp_next = CP_WIDTH'(b[4:0]);
                exp_next = 2'd1;
                seq_next = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                pcp_next = CP_WIDTH'(b[3:0]);
                exp_next = 2'd2;
                seq_next = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                pcp_next = CP_WIDTH'(b[2:0]);
                exp_next = 2'd3;
                seq_next = 2'd3;
            end
            else
            begin
                err_next = ERR_MALFORMED;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            err_next = ERR_MALFORMED;
        end
        else
        begin
            pcp_next = cp_full;
            exp_next = exp_reg - 2'd1;
            if (exp_reg == 2'd1)
            begin
                cp = cp_full;
                if (seq_reg == 2'd1)
                begin
                    cp_bad = cp_full < TWO_BYTE_MIN;
                end
                else if (seq_reg == 2'd2)
                begin
                    cp_bad = cp_full < THREE_BYTE_MIN
                             || (cp_full >= SURR_FIRST && cp_full <= SURR_LAST);
                end
                else
                begin
                    cp_bad = cp_full < BMP_LIMIT || cp_full > CP_MAX;
                end
                pcp_next = '0;
                seq_next = 2'd0;
                if (cp_bad)
                begin
                    err_next = ERR_MALFORMED;
                end
                else
                begin
                    do_emit = 1'b1;
                end
            end
        end

        if (do_emit)
        begin
            cp_off = cp - BMP_LIMIT;
            if (cp < BMP_LIMIT)
            begin
                if (units_ext >= cap_eff)
                begin
                    err_next = ERR_CAPACITY;
                end
                else
                begin
                    res0.kind      = KIND_UNIT;
                    res0.code_unit = cp[UNIT_WIDTH-1:0];
                    res0.last      = 1'b1;
                    push_n         = 2'd1;
                    units_next     = COUNT_WIDTH'(units_ext + CMP_WIDTH'(1));
                end
            end
            else if (units_ext + CMP_WIDTH'(1) >= cap_eff)
            begin
                err_next = ERR_CAPACITY;
            end
            else
            begin
                res0.kind      = KIND_UNIT;
                res0.code_unit = HI_SURR_BASE | UNIT_WIDTH'(cp_off[19:10]);
                res1.kind      = KIND_UNIT;
                res1.code_unit = LO_SURR_BASE | UNIT_WIDTH'(cp_off[9:0]);
                res1.last      = 1'b1;
                push_n         = 2'd2;
                units_next     = COUNT_WIDTH'(units_ext + CMP_WIDTH'(2));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_WIDTH'(4095);
            pcp_reg   <= '0;
            exp_reg   <= 2'd0;
            seq_reg   <= 2'd0;
            units_reg <= '0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
            if (s_acc)
            begin
                pcp_reg   <= pcp_next;
                exp_reg   <= exp_next;
                seq_reg   <= seq_next;
                units_reg <= units_next;
                err_reg   <= err_next;
            end
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (s_acc && push_n != 2'd0)
        begin
            fifo_reg[wptr_reg] <= res0;
        end
        if (s_acc && push_n == 2'd2)
        begin
            fifo_reg[wptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 2'd0;
            rptr_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            if (s_acc)
            begin
                wptr_reg <= wptr_reg + push_n;
            end
            if (m_acc)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + (s_acc ? 3'(push_n) : 3'd0) - (m_acc ? 3'd1 : 3'd0);
        end
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {2'b00, fifo_reg[rptr_reg].unit_total, fifo_reg[rptr_reg].status,
                       fifo_reg[rptr_reg].code_unit};
    assign m_tuser  = fifo_reg[rptr_reg].kind;
    assign m_tlast  = fifo_reg[rptr_reg].last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overfilled");

    a_exp_le_seq: assert property (@(posedge clk) disable iff (!rst_n)
        exp_reg <= seq_reg)
        else $error("expected bytes exceed sequence length");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tdata == 8'h00) |=> (err_reg == ERR_NONE && units_reg == '0
                                         && exp_reg == 2'd0))
        else $error("terminator did not clear text state");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end result without last flag");

    a_no_units_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && err_reg != ERR_NONE && s_tdata != 8'h00) |-> (push_n == 2'd0))
        else $error("unit emitted after error");
`endif

endmodule

`default_nettype wire
